// ===== design/lcrp_pkg.sv =====
// ----------------------------------------------------------------------------
// lcrp_pkg
// Shared types and constants for the LED controller reply parser: protocol
// characters, event codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package lcrp_pkg;

  // Protocol characters.
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_A = 8'h41;

  // Event codes carried in event_res.
  typedef enum logic [2:0] {
    EV_SENSOR  = 3'd0,
    EV_CURTAIN = 3'd1,
    EV_LED     = 3'd2,
    EV_INIT    = 3'd3,
    EV_PANIC   = 3'd4,
    EV_UNKNOWN = 3'd5,
    EV_BADLEN  = 3'd6
  } event_t;

  // One result request.
  typedef struct packed {
    logic [2:0] event_res;
    logic [6:0] index;
    logic [7:0] value;
    logic [7:0] extra;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ===== design/lcrp_parser.sv =====
// ----------------------------------------------------------------------------
// lcrp_parser
// Frame tracker: follows the sync pair, command byte and arguments, and forms
// at most one result for each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrp_parser
  import lcrp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output logic            res_hit,
  output res_t            res
);

  typedef enum logic [7:0] {
    PH_HUNT_O  = 8'b0000_0001,
    PH_HUNT_K  = 8'b0000_0010,
    PH_CMD     = 8'b0000_0100,
    PH_ONE_ARG = 8'b0000_1000,
    PH_M_POS   = 8'b0001_0000,
    PH_M_LIM   = 8'b0010_0000,
    PH_L_LEN   = 8'b0100_0000,
    PH_L_DATA  = 8'b1000_0000
  } phase_t;

  phase_t     phase, phase_next;
  logic       is_init, is_init_next;
  logic [7:0] first_arg, first_arg_next;
  logic [6:0] remaining, remaining_next;
  logic [6:0] channel_index, channel_index_next;
  logic       led_last;

  // The final LED value of a frame is seen when one or none remain.
  assign led_last = (remaining[6:1] == 6'd0);

  // Next state and the result for the byte on the input.
  always_comb begin
    phase_next         = phase;
    is_init_next       = is_init;
    first_arg_next     = first_arg;
    remaining_next     = remaining;
    channel_index_next = channel_index;
    res_hit            = 1'b0;
    res                = '0;
    res.last           = 1'b1;
    unique case (phase)
      PH_HUNT_O: begin
        if (rx_byte == CH_O) phase_next = PH_HUNT_K;
      end
      PH_HUNT_K: begin
        if (rx_byte == CH_K) phase_next = PH_CMD;
        else if (rx_byte != CH_O) phase_next = PH_HUNT_O;
      end
      PH_CMD: begin
        priority if (rx_byte == CH_S || rx_byte == CH_I) begin
          is_init_next = (rx_byte == CH_I);
          phase_next   = PH_ONE_ARG;
        end else if (rx_byte == CH_M) begin
          phase_next = PH_M_POS;
        end else if (rx_byte == CH_L) begin
          phase_next = PH_L_LEN;
        end else if (rx_byte == CH_A) begin
          phase_next    = PH_HUNT_O;
          res_hit       = 1'b1;
          res.event_res = EV_PANIC;
        end else begin
          phase_next    = PH_HUNT_O;
          res_hit       = 1'b1;
          res.event_res = EV_UNKNOWN;
          res.value     = rx_byte;
        end
      end
      PH_ONE_ARG: begin
        phase_next    = PH_HUNT_O;
        res_hit       = 1'b1;
        res.event_res = is_init ? EV_INIT : EV_SENSOR;
        res.value     = rx_byte;
      end
      PH_M_POS: begin
        first_arg_next = rx_byte;
        phase_next     = PH_M_LIM;
      end
      PH_M_LIM: begin
        phase_next    = PH_HUNT_O;
        res_hit       = 1'b1;
        res.event_res = EV_CURTAIN;
        res.value     = first_arg;
        res.extra     = rx_byte;
      end
      PH_L_LEN: begin
        if (rx_byte == 8'd0 || rx_byte[7]) begin
          phase_next    = PH_HUNT_O;
          res_hit       = 1'b1;
          res.event_res = EV_BADLEN;
          res.value     = rx_byte;
        end else begin
          remaining_next     = rx_byte[6:0];
          channel_index_next = 7'd0;
          phase_next         = PH_L_DATA;
        end
      end
      PH_L_DATA: begin
        res_hit            = 1'b1;
        res.event_res      = EV_LED;
        res.index          = channel_index;
        res.value          = rx_byte;
        res.last           = led_last;
        remaining_next     = remaining - 7'd1;
        channel_index_next = channel_index + 7'd1;
        if (led_last) begin
          remaining_next = 7'd0;
          phase_next     = PH_HUNT_O;
        end
      end
      default: begin
        phase_next = PH_HUNT_O;
      end
    endcase
  end

  // State advances only on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT_O;
      is_init       <= 1'b0;
      first_arg     <= 8'd0;
      remaining     <= 7'd0;
      channel_index <= 7'd0;
    end else if (accept) begin
      phase         <= phase_next;
      is_init       <= is_init_next;
      first_arg     <= first_arg_next;
      remaining     <= remaining_next;
      channel_index <= channel_index_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/lcrp_out_stage.sv =====
// ----------------------------------------------------------------------------
// lcrp_out_stage
// Result register with a skid entry, so that the input side keeps running
// while a finished result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrp_out_stage
  import lcrp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_res,
  output logic      full,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  logic skid_valid;
  res_t skid;
  logic pop;

  assign pop  = res_valid && !res_stall;
  assign full = skid_valid;

  // Control: the skid entry fills only when the result register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) skid_valid <= 1'b0;
      end else if (push && res_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      if (!res_valid || pop) res_valid <= skid_valid || push;
    end
  end

  // Payload moves with its control.
  always_ff @(posedge clk) begin
    if (!skid_valid && push && res_valid && !pop) skid <= push_res;
    if (!res_valid || pop) begin
      if (skid_valid) res <= skid;
      else if (push) res <= push_res;
    end
  end

endmodule

`default_nettype wire

// ===== design/led_controller_reply_parser.sv =====
// ----------------------------------------------------------------------------
// led_controller_reply_parser
// Parses the reply byte stream of an LED and curtain controller.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle while rx_stall is low and
// answers it with at most one result request, which appears on the result port
// in the cycle after the byte is taken, unless an earlier result is still held
// there by res_stall, in which case it follows as soon as that one is taken.
// The byte is decoded against the frame state in a single pass and the result
// goes into an output register with one skid entry; rx_stall rises only when
// both hold a result that the receiver has not taken. After reset the parser
// hunts for the 'O','K' sync pair; bytes outside frames produce nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module led_controller_reply_parser
  import lcrp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [2:0]      event_res,
  output logic [6:0]      index,
  output logic [7:0]      value,
  output logic [7:0]      extra,
  output logic            last
);

  logic accept;
  logic hit;
  res_t new_res;
  res_t out_res;

  assign accept = rx_valid && !rx_stall;

  // Frame tracking and result forming.
  lcrp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .res_hit (hit),
    .res     (new_res)
  );

  // Output register and skid entry.
  lcrp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && hit),
    .push_res  (new_res),
    .full      (rx_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (out_res)
  );

  assign event_res = out_res.event_res;
  assign index     = out_res.index;
  assign value     = out_res.value;
  assign extra     = out_res.extra;
  assign last      = out_res.last;

endmodule

`default_nettype wire

// ===== design/lcrp_checker.sv =====
// ----------------------------------------------------------------------------
// lcrp_checker
// Port-level checks for the reply parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrp_checker
  import lcrp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_valid,
  input wire logic       rx_stall,
  input wire logic [7:0] rx_byte,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic [2:0] event_res,
  input wire logic [6:0] index,
  input wire logic [7:0] value,
  input wire logic [7:0] extra,
  input wire logic       last
);

  // A held result request stays put until taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(event_res) && $stable(index)
      && $stable(value) && $stable(extra) && $stable(last))
    else $error("result request changed while stalled");

  // No result is pending straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result pending after reset");

  // Only LED events carry a channel number or may be non-final.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res != EV_LED |-> last && index == 7'd0)
    else $error("non-LED result with index or without last");

  // Only curtain events carry the limit; a panic acknowledge carries nothing.
  a_extra_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res != EV_CURTAIN |-> extra == 8'd0 &&
      (event_res != EV_PANIC || value == 8'd0))
    else $error("unexpected payload on result");

endmodule

bind led_controller_reply_parser lcrp_checker u_lcrp_checker (.*);

`default_nettype wire

// ===== dv/led_controller_reply_parser_test.sv =====
// ----------------------------------------------------------------------------
// led_controller_reply_parser_test
// Self-checking testbench for the LED controller reply parser. Byte requests
// are driven through the valid/stall handshake and mirrored into a
// cycle-free model of the frame parser. Each result request is then checked
// field by field against the oldest predicted event. Both sides idle at
// random, and there are stretches without idling. The receiver holds off
// long enough to back the parser up into its input, and the sender waits
// for the results to drain at set points.
// ----------------------------------------------------------------------------

module led_controller_reply_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcrp_pkg::*;

  localparam int MAX_GAP       = 17;
  localparam int HOLD_CYCLES   = 80;
  localparam int QUIET_LIMIT   = 2000;
  localparam int ITEM_TARGET   = 1250;
  localparam int SETTLE_CYCLES = 8;
  localparam int OPENING_LEN   = 31;

  // Opening sequence: the edges of the byte range and every command.
  localparam logic [7:0] OPENING [OPENING_LEN] = '{
    8'h00, CH_K,                          // stray bytes while hunting
    CH_O, CH_O, CH_K, 8'hFF,              // repeated O, then unknown command
    CH_O, CH_K, CH_A,                     // panic acknowledge
    CH_O, CH_K, CH_S, 8'hFF,              // sensor
    CH_O, CH_K, CH_I, 8'h00,              // init
    CH_O, CH_K, CH_M, 8'h00, 8'hFF,       // curtain
    CH_O, CH_K, CH_L, 8'h02, 8'hAA, 8'h55, // two LED channels
    CH_O, CH_K, CH_L                      // followed by a bad length of zero
  };

  typedef enum logic [2:0] {
    P_HUNT_O, P_HUNT_K, P_CMD, P_ONE_ARG, P_M_POS, P_M_LIM, P_L_LEN, P_L_DATA
  } parse_phase_t;

  // Frame parser model, queue of awaited events and result checking.
  class reply_scoreboard;
    parse_phase_t phase;
    logic [7:0]   one_arg_cmd;
    logic [7:0]   pos_held;
    logic [7:0]   curtain_pos;
    logic [7:0]   curtain_lim;
    logic [6:0]   leds_left;
    logic [6:0]   led_chan;
    res_t         awaited_events[$];
    int           mismatches;
    int           checked;
    int           framed_bytes;
    int           taken_bytes;
    int           per_event[8];

    function new();
      phase        = P_HUNT_O;
      one_arg_cmd  = '0;
      pos_held     = '0;
      curtain_pos  = '0;
      curtain_lim  = '0;
      leds_left    = '0;
      led_chan     = '0;
      mismatches   = 0;
      checked      = 0;
      framed_bytes = 0;
      taken_bytes  = 0;
      foreach (per_event[i]) per_event[i] = 0;
    endfunction

    function int pending();
      return awaited_events.size();
    endfunction

    // Advance the parser model by one accepted byte request.
    function void take_byte(logic [7:0] b);
      res_t r;
      bit   gives;
      r      = '0;
      r.last = 1'b1;
      gives  = 1'b0;
      taken_bytes++;
      if (phase != P_HUNT_O) framed_bytes++;
      case (phase)
        P_HUNT_O: begin
          if (b == CH_O) phase = P_HUNT_K;
        end
        P_HUNT_K: begin
          if (b == CH_K) phase = P_CMD;
          else if (b != CH_O) phase = P_HUNT_O;
        end
        P_CMD: begin
          phase = P_HUNT_O;
          if (b == CH_S || b == CH_I) begin
            one_arg_cmd = b;
            phase       = P_ONE_ARG;
          end else if (b == CH_M) begin
            phase = P_M_POS;
          end else if (b == CH_L) begin
            phase = P_L_LEN;
          end else if (b == CH_A) begin
            gives       = 1'b1;
            r.event_res = EV_PANIC;
          end else begin
            gives       = 1'b1;
            r.event_res = EV_UNKNOWN;
            r.value     = b;
          end
        end
        P_ONE_ARG: begin
          phase       = P_HUNT_O;
          gives       = 1'b1;
          r.event_res = (one_arg_cmd == CH_I) ? EV_INIT : EV_SENSOR;
          r.value     = b;
        end
        P_M_POS: begin
          pos_held = b;
          phase    = P_M_LIM;
        end
        P_M_LIM: begin
          curtain_pos = pos_held;
          curtain_lim = b;
          phase       = P_HUNT_O;
          gives       = 1'b1;
          r.event_res = EV_CURTAIN;
          r.value     = curtain_pos;
          r.extra     = curtain_lim;
        end
        P_L_LEN: begin
          if (b == 8'd0 || b > 8'd127) begin
            phase       = P_HUNT_O;
            gives       = 1'b1;
            r.event_res = EV_BADLEN;
            r.value     = b;
          end else begin
            leds_left = b[6:0];
            led_chan  = '0;
            phase     = P_L_DATA;
          end
        end
        P_L_DATA: begin
          gives       = 1'b1;
          r.event_res = EV_LED;
          r.index     = led_chan;
          r.value     = b;
          r.last      = (leds_left <= 7'd1);
          leds_left   = leds_left - 7'd1;
          led_chan    = led_chan + 7'd1;
          if (r.last) begin
            leds_left = '0;
            phase     = P_HUNT_O;
          end
        end
      endcase
      if (gives) awaited_events.push_back(r);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    // Compare one accepted result request with the oldest awaited event.
    function void check_result(res_t got);
      res_t want;
      checked++;
      per_event[got.event_res]++;
      if (awaited_events.size() == 0) begin
        flag($sformatf("result with nothing awaited: event %0d index %0d value %h",
                       got.event_res, got.index, got.value));
      end else begin
        want = awaited_events.pop_front();
        if (got.event_res !== want.event_res)
          flag($sformatf("event_res expected %0d got %0d", want.event_res, got.event_res));
        if (got.index !== want.index)
          flag($sformatf("index expected %0d got %0d", want.index, got.index));
        if (got.value !== want.value)
          flag($sformatf("value expected %h got %h", want.value, got.value));
        if (got.extra !== want.extra)
          flag($sformatf("extra expected %h got %h", want.extra, got.extra));
        if (got.last !== want.last)
          flag($sformatf("last expected %b got %b", want.last, got.last));
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_byte;
  logic       res_valid;
  logic       res_stall;
  logic [2:0] event_res;
  logic [6:0] index;
  logic [7:0] value;
  logic [7:0] extra;
  logic       last;

  reply_scoreboard sb = new();
  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  led_controller_reply_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .event_res (event_res),
    .index     (index),
    .value     (value),
    .extra     (extra),
    .last      (last)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one byte after a random gap and wait until it is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) @(negedge clk) rx_valid <= 1'b0;
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!(rx_valid && !rx_stall));
    sb.take_byte(b);
  endtask

  task automatic send_sync();
    send_byte(CH_O);
    send_byte(CH_K);
  endtask

  // A complete frame with random content; long LED frames are rare.
  task automatic send_frame();
    int n;
    int pick;
    send_sync();
    case ($urandom_range(0, 4))
      0: begin
        send_byte(CH_S);
        send_byte(8'($urandom_range(0, 255)));
      end
      1: begin
        send_byte(CH_I);
        send_byte(8'($urandom_range(0, 255)));
      end
      2: begin
        send_byte(CH_M);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        pick = $urandom_range(0, 59);
        if (pick == 0) n = 127;
        else if (pick == 1) n = $urandom_range(9, 126);
        else n = $urandom_range(1, 8);
        send_byte(CH_L);
        send_byte(8'(n));
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        send_byte(CH_A);
      end
    endcase
  endtask

  // Malformed traffic: bad commands, bad lengths, broken sync, short frames.
  task automatic send_broken();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: begin
        do b = 8'($urandom_range(0, 255));
        while (b inside {CH_S, CH_M, CH_L, CH_I, CH_A});
        send_sync();
        send_byte(b);
      end
      1: begin
        send_sync();
        send_byte(CH_L);
        send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(128, 255)));
      end
      2: begin
        repeat ($urandom_range(1, 3)) send_byte(CH_O);
        send_frame();
      end
      3: begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_O || b == CH_K);
        send_byte(CH_O);
        send_byte(b);
        send_byte(CH_K);
      end
      default: begin
        // The frame is cut short, so the bytes that follow become its arguments.
        send_sync();
        send_byte($urandom_range(0, 1) ? CH_M : CH_L);
      end
    endcase
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic wait_for_results();
    @(negedge clk) rx_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stall before each request, long hold when asked.
  initial begin : result_sink
    int   stall_left;
    res_t got;
    res_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      res_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        got.event_res = event_res;
        got.index     = index;
        got.value     = value;
        got.extra     = extra;
        got.last      = last;
        sb.check_result(got);
        stall_left = steady ? 0 : $urandom_range(0, MAX_GAP);
      end
    end
  end

  // Watchdog: end the run if no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no request accepted for %0d cycles.", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus and final report.
  initial begin : byte_source
    int pick;
    rst      = 1'b1;
    rx_valid = 1'b0;
    rx_byte  = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (OPENING[i]) send_byte(OPENING[i]);
    send_byte(8'h00);

    // Back the parser up: the receiver holds while a long LED frame streams in.
    wait_for_results();
    hold_req = 1'b1;
    steady   = 1'b1;
    send_sync();
    send_byte(CH_L);
    send_byte(8'd24);
    repeat (24) send_byte(8'($urandom_range(0, 255)));
    steady = 1'b0;

    // Random traffic, mostly well-formed frames.
    while (sb.taken_bytes < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) steady = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame();
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 98) begin
        send_broken();
      end else if (pick == 98) begin
        wait_for_results();
      end else begin
        hold_req = 1'b1;
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes, %0d inside frames, and %0d results, %0d mismatching.",
             sb.taken_bytes, sb.framed_bytes, sb.checked, sb.mismatches);
    $display("Events: sensor %0d, curtain %0d, led %0d, init %0d,",
             sb.per_event[EV_SENSOR], sb.per_event[EV_CURTAIN], sb.per_event[EV_LED],
             sb.per_event[EV_INIT]);
    $display("        panic %0d, unknown %0d, bad length %0d.",
             sb.per_event[EV_PANIC], sb.per_event[EV_UNKNOWN], sb.per_event[EV_BADLEN]);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
